// ===== hdl/ccsac_pkg.sv =====
// shared types and constants of the cone core/shell atom classifier
package ccsac_pkg;

   localparam int MATERIALS = 8;
   localparam int MAT_W     = $clog2(MATERIALS);
   localparam int RR_W      = 40;

   typedef enum logic [2:0] {
      CSR_ORIGIN_X      = 3'd0,
      CSR_ORIGIN_Y      = 3'd1,
      CSR_INV_RADIUS_SQ = 3'd2,
      CSR_CONE_HEIGHT   = 3'd3,
      CSR_INV_HEIGHT_SQ = 3'd4,
      CSR_GRAIN_ID      = 3'd5,
      CSR_FILL_SHELLS   = 3'd6
   } csr_index_type;

   typedef enum logic {
      OP_CLASSIFY = 1'b0,
      OP_LOAD     = 1'b1
   } operation_type;

   typedef struct packed {
      logic               operation;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [2:0]         atom_material;
      logic [7:0]         atom_category;
      logic               include_in;
      logic [2:0]         table_index;
      logic [19:0]        shell_radius;
      logic signed [31:0] shell_z_min;
      logic signed [31:0] shell_z_max;
      logic [7:0]         shell_category;
   } req_payload_type;

   typedef struct packed {
      logic       include_out;
      logic [2:0] material_out;
      logic       grain_set;
   } rsp_payload_type;

   typedef struct packed {
      logic [RR_W-1:0]    radius_sq;
      logic signed [31:0] z_min;
      logic signed [31:0] z_max;
      logic [7:0]         category;
   } shell_entry_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_LDM, ST_LDW,
      ST_SQX, ST_MXL, ST_MXH,
      ST_SQY, ST_MYL, ST_MYH,
      ST_SQT, ST_MTL, ST_MTH,
      ST_BSUM, ST_WL, ST_WH, ST_WC, ST_FIN
   } state_type;

endpackage

// ===== hdl/ccsac_req_if.sv =====
// request channel: valid/ready with an atom or table load beat
interface ccsac_req_if import ccsac_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/ccsac_rsp_if.sv =====
// response channel: valid/ready with a classification beat
interface ccsac_rsp_if import ccsac_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/cone_core_shell_atom_classifier_top.sv =====
// classify atom: 10 setup steps on one shared 33x40 multiplier, then 3 per shell entry
// when the atom's material has a shell; with none, the shell walk is skipped
// table load: radius square on the multiplier, then memory write
// one item at a time, next accept once the response is issued;
// a new item is taken while a response waits to be taken
// synchronous reset clears config and control registers, marks every shell entry as zero
module cone_core_shell_atom_classifier_top import ccsac_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   ccsac_req_if.sink   req,
   ccsac_rsp_if.source rsp,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic [31:0] origin_x_ff, origin_y_ff, inv_r_ff, cone_h_ff, inv_h_ff;
   logic [15:0] grain_id_ff;
   logic        fill_ff;

   state_type state_ff, state_in;

   logic [19:0]      radius_ff [MATERIALS];
   logic [MAT_W-1:0] rank_ff [MATERIALS];
   logic [MAT_W-1:0] rank_in [MATERIALS];
   logic [MATERIALS-1:0] valid_ff;

   shell_entry_type shell_mem [MATERIALS];
   shell_entry_type rdata_ff;
   logic            rvalid_ff;
   shell_entry_type entry;
   logic            rd_en;
   logic [MAT_W-1:0] rd_addr;

   // latched item
   logic [32:0]      dxa_ff, dya_ff, ta_ff;
   logic [31:0]      z_ff;
   logic [2:0]       mat_ff;
   logic [7:0]       cat_ff;
   logic             inc_ff, grain_ff;
   logic [MAT_W-1:0] ld_idx_ff;
   logic [19:0]      ld_r_ff;
   logic [31:0]      ld_zmin_ff, ld_zmax_ff;
   logic [7:0]       ld_cat_ff;

   logic [32:0]      mul_a;
   logic [RR_W-1:0]  mul_b;
   logic [72:0]      prod_ff;
   logic [31:0]      hi_ff;
   logic [64:0]      acc_ff;
   logic [63:0]      b_ff, b_sum;
   logic [71:0]      racc_ff;
   logic [MAT_W-1:0] step_ff, look, sel, m_ff;
   logic             rsp_valid_ff;
   rsp_payload_type  rsp_ff;

   logic [32:0] dx, dy, dt;
   logic [104:0] rhs, lhs_sh;
   logic         in_shell, shell_match, no_shell, accept, rsp_free;

   assign accept   = req.valid && req.ready;
   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;
   assign rsp_free  = !rsp_valid_ff || rsp.ready;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         inv_r_ff    <= '0;
         cone_h_ff   <= '0;
         inv_h_ff    <= '0;
         grain_id_ff <= '0;
         fill_ff     <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ORIGIN_X:      origin_x_ff <= csr_wdata;
            CSR_ORIGIN_Y:      origin_y_ff <= csr_wdata;
            CSR_INV_RADIUS_SQ: inv_r_ff    <= csr_wdata;
            CSR_CONE_HEIGHT:   cone_h_ff   <= csr_wdata;
            CSR_INV_HEIGHT_SQ: inv_h_ff    <= csr_wdata;
            CSR_GRAIN_ID:      grain_id_ff <= csr_wdata[15:0];
            CSR_FILL_SHELLS:   fill_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // walk position of each entry: ascending radius, ties by index
   always_comb begin
      for (int k = 0; k < MATERIALS; k++) begin
         rank_in[k] = '0;
         for (int j = 0; j < MATERIALS; j++) begin
            if (j != k && ((radius_ff[j] < radius_ff[k]) ||
                           (radius_ff[j] == radius_ff[k] && j < k))) begin
               rank_in[k] = rank_in[k] + MAT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MATERIALS; k++) begin
            radius_ff[k] <= '0;
            rank_ff[k]   <= MAT_W'(k);
         end
      end else begin
         for (int k = 0; k < MATERIALS; k++) begin
            rank_ff[k] <= rank_in[k];
         end
         if (accept && req.data.operation == OP_LOAD) begin
            radius_ff[req.data.table_index[MAT_W-1:0]] <= req.data.shell_radius;
         end
      end
   end

   // entry holding walk position look
   assign look = (state_ff == ST_BSUM) ? MAT_W'(0) :
                 (state_ff == ST_WC)   ? step_ff + MAT_W'(1) : step_ff;
   always_comb begin
      sel = '0;
      for (int k = 0; k < MATERIALS; k++) begin
         if (rank_ff[k] == look) begin
            sel = MAT_W'(k);
         end
      end
   end

   // shell table memory
   assign rd_addr = sel;
   always_ff @(posedge clock) begin
      if (state_ff == ST_LDW) begin
         shell_mem[ld_idx_ff] <= '{radius_sq: prod_ff[RR_W-1:0], z_min: ld_zmin_ff,
                                   z_max: ld_zmax_ff, category: ld_cat_ff};
      end
      if (rd_en) begin
         rdata_ff <= shell_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_LDW) begin
            valid_ff[ld_idx_ff] <= 1'b1;
         end
         if (rd_en) begin
            rvalid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign entry = rvalid_ff ? rdata_ff : '0;

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_LDM:  begin mul_a = 33'(ld_r_ff);          mul_b = RR_W'(ld_r_ff); end
         ST_SQX:  begin mul_a = dxa_ff;                mul_b = RR_W'(dxa_ff); end
         ST_SQY:  begin mul_a = dya_ff;                mul_b = RR_W'(dya_ff); end
         ST_SQT:  begin mul_a = ta_ff;                 mul_b = RR_W'(ta_ff); end
         ST_MXL, ST_MYL: begin
            mul_a = 33'(prod_ff[31:0]); mul_b = RR_W'(inv_r_ff);
         end
         ST_MXH, ST_MYH: begin
            mul_a = 33'(hi_ff); mul_b = RR_W'(inv_r_ff);
         end
         ST_MTL:  begin mul_a = 33'(prod_ff[31:0]);   mul_b = RR_W'(inv_h_ff); end
         ST_MTH:  begin mul_a = 33'(hi_ff);           mul_b = RR_W'(inv_h_ff); end
         ST_WL:   begin mul_a = 33'(b_ff[31:0]);      mul_b = entry.radius_sq; end
         ST_WH:   begin mul_a = 33'(b_ff[63:32]);     mul_b = entry.radius_sq; end
         default: ;
      endcase
   end

   assign dx = {origin_x_ff[31], origin_x_ff} - {req.data.pos_x[31], req.data.pos_x};
   assign dy = {origin_y_ff[31], origin_y_ff} - {req.data.pos_y[31], req.data.pos_y};
   assign dt = {cone_h_ff[31], cone_h_ff} - {req.data.pos_z[31], req.data.pos_z};

   assign b_sum    = b_ff + prod_ff[63:0];
   assign no_shell = (radius_ff[mat_ff] == '0);
   // lhs <= floor(b * rr / 2^32) is the same as lhs * 2^32 <= b * rr
   assign rhs      = {prod_ff, 32'b0} + 105'(racc_ff);
   assign lhs_sh   = 105'({acc_ff, 32'b0});
   assign in_shell = (lhs_sh <= rhs);
   assign shell_match = ($signed(z_ff) >= entry.z_min) && ($signed(z_ff) < entry.z_max)
                        && (cat_ff == entry.category);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req.data.operation == OP_LOAD) ? ST_LDM : ST_SQX;
            end
         end
         ST_LDM:  state_in = ST_LDW;
         ST_LDW:  state_in = ST_IDLE;
         ST_SQX:  state_in = ST_MXL;
         ST_MXL:  state_in = ST_MXH;
         ST_MXH:  state_in = ST_SQY;
         ST_SQY:  state_in = ST_MYL;
         ST_MYL:  state_in = ST_MYH;
         ST_MYH:  state_in = ST_SQT;
         ST_SQT:  state_in = ST_MTL;
         ST_MTL:  state_in = ST_MTH;
         ST_MTH:  state_in = ST_BSUM;
         ST_BSUM: state_in = no_shell ? ST_FIN : ST_WL;
         ST_WL:   state_in = ST_WH;
         ST_WH:   state_in = ST_WC;
         ST_WC:   state_in = (step_ff == MAT_W'(MATERIALS - 1)) ? ST_FIN : ST_WL;
         ST_FIN:  state_in = rsp_free ? ST_IDLE : ST_FIN;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      rd_en = (state_ff == ST_BSUM && !no_shell) ||
              (state_ff == ST_WC && step_ff != MAT_W'(MATERIALS - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_FIN && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      prod_ff <= 73'(mul_a * mul_b);
      if (rd_en) begin
         m_ff <= sel;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               dxa_ff     <= dx[32] ? -dx : dx;
               dya_ff     <= dy[32] ? -dy : dy;
               ta_ff      <= dt[32] ? -dt : dt;
               z_ff       <= req.data.pos_z;
               mat_ff     <= req.data.atom_material;
               cat_ff     <= req.data.atom_category;
               inc_ff     <= req.data.include_in;
               grain_ff   <= 1'b0;
               ld_idx_ff  <= req.data.table_index[MAT_W-1:0];
               ld_r_ff    <= req.data.shell_radius;
               ld_zmin_ff <= req.data.shell_z_min;
               ld_zmax_ff <= req.data.shell_z_max;
               ld_cat_ff  <= req.data.shell_category;
            end
         end
         ST_MXL, ST_MYL, ST_MTL: hi_ff <= prod_ff[63:32];
         ST_MXH:  acc_ff <= 65'(prod_ff[63:32]);
         ST_SQY, ST_SQT: acc_ff <= acc_ff + 65'(prod_ff[63:0]);
         ST_MYH:  acc_ff <= acc_ff + 65'(prod_ff[63:32]);
         ST_MTH:  b_ff <= 64'(prod_ff[63:32]);
         ST_BSUM: begin
            b_ff    <= b_sum;
            step_ff <= '0;
            if (no_shell && acc_ff <= {1'b0, b_sum}) begin
               inc_ff   <= 1'b1;
               grain_ff <= 1'b1;
            end
         end
         ST_WH:   racc_ff <= prod_ff[71:0];
         ST_WC: begin
            step_ff <= step_ff + MAT_W'(1);
            if (in_shell) begin
               if (shell_match) begin
                  inc_ff   <= 1'b1;
                  mat_ff   <= 3'(m_ff);
                  grain_ff <= 1'b1;
               end else if (!fill_ff) begin
                  inc_ff <= 1'b0;
               end
            end
         end
         ST_FIN: begin
            if (rsp_free) begin
               rsp_ff <= '{include_out: inc_ff, material_out: mat_ff, grain_set: grain_ff};
            end
         end
         default: ;
      endcase
   end

endmodule

// ===== dv/cone_core_shell_atom_classifier_top_tb.sv =====
// testbench for the cone core/shell atom classifier: directed and random beats, checked in order
module cone_core_shell_atom_classifier_top_tb;
   import ccsac_pkg::*;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   ccsac_req_if req_if ();
   ccsac_rsp_if rsp_if ();

   cone_core_shell_atom_classifier_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // mirror of the block's registers and shell table
   logic [31:0] org_x, org_y, inv_rsq, apex_z, inv_hsq;
   logic [15:0] grain_num;
   logic        fill_on;
   logic [19:0] shell_size [MATERIALS];
   logic [31:0] shell_lo   [MATERIALS];
   logic [31:0] shell_hi   [MATERIALS];
   logic [7:0]  shell_cat  [MATERIALS];

   rsp_payload_type pending_cls[$];
   int unsigned     error_count;
   int unsigned     burst_left;
   logic [7:0]      ready_pattern;
   int unsigned     pattern_age;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   initial begin
      #8000000;
      $display("*** FAILED ***");
      $finish;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
   endtask

   function automatic logic [127:0] diff_square(input logic [31:0] a, input logic [31:0] b);
      logic signed [33:0] d;
      logic [33:0]        m;
      d = $signed({{2{a[31]}}, a}) - $signed({{2{b[31]}}, b});
      m = d[33] ? -d : d;
      diff_square = {94'b0, m} * {94'b0, m};
   endfunction

   function automatic rsp_payload_type classify_atom(input req_payload_type p);
      rsp_payload_type res;
      logic [127:0] lhs, rhs, rr, bterm;
      logic [2:0]   order [MATERIALS];
      logic [2:0]   k;
      int           i, j;
      res.include_out  = p.include_in;
      res.material_out = p.atom_material;
      res.grain_set    = 1'b0;
      lhs = ((diff_square(p.pos_x, org_x) * {96'b0, inv_rsq}) >> 32)
          + ((diff_square(p.pos_y, org_y) * {96'b0, inv_rsq}) >> 32);
      bterm = (diff_square(apex_z, p.pos_z) * {96'b0, inv_hsq}) >> 32;
      bterm = {64'b0, bterm[63:0]};
      if (shell_size[p.atom_material] != 0) begin
         // stable ascending sort by shell size
         for (i = 0; i < MATERIALS; i++) order[i] = i[2:0];
         for (i = 1; i < MATERIALS; i++) begin
            k = order[i];
            j = i - 1;
            while (j >= 0 && shell_size[order[j]] > shell_size[k]) begin
               order[j + 1] = order[j];
               j--;
            end
            order[j + 1] = k;
         end
         for (i = 0; i < MATERIALS; i++) begin
            k   = order[i];
            rr  = {108'b0, shell_size[k]} * {108'b0, shell_size[k]};
            rhs = (bterm * rr) >> 32;
            if (lhs <= rhs) begin
               if ($signed(p.pos_z) >= $signed(shell_lo[k]) && $signed(p.pos_z) < $signed(shell_hi[k])
                   && p.atom_category == shell_cat[k]) begin
                  res.include_out  = 1'b1;
                  res.material_out = k;
                  res.grain_set    = 1'b1;
               end else if (!fill_on) begin
                  res.include_out = 1'b0;
               end
            end
         end
      end else if (lhs <= bterm) begin
         res.include_out = 1'b1;
         res.grain_set   = 1'b1;
      end
      return res;
   endfunction

   // one beat on the request channel; called at a falling edge, returns at one
   task automatic send_item(input req_payload_type p);
      int unsigned gap;
      req_if.valid <= 1'b1;
      req_if.data  <= p;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (p.operation == OP_LOAD) begin
         shell_size[p.table_index] = p.shell_radius;
         shell_lo[p.table_index]   = p.shell_z_min;
         shell_hi[p.table_index]   = p.shell_z_max;
         shell_cat[p.table_index]  = p.shell_category;
      end else begin
         pending_cls.insert(pending_cls.size(), classify_atom(p));
      end
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   // stop sending and let every classification come back
   task automatic drain_block();
      req_if.valid <= 1'b0;
      while (pending_cls.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_ORIGIN_X:      org_x = value;
         CSR_ORIGIN_Y:      org_y = value;
         CSR_INV_RADIUS_SQ: inv_rsq = value;
         CSR_CONE_HEIGHT:   apex_z = value;
         CSR_INV_HEIGHT_SQ: inv_hsq = value;
         CSR_GRAIN_ID:      grain_num = value[15:0];
         CSR_FILL_SHELLS:   fill_on = value[0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic write_all_regs(input logic [31:0] ox, input logic [31:0] oy,
                                 input logic [31:0] irsq, input logic [31:0] h,
                                 input logic [31:0] ihsq, input logic [15:0] g,
                                 input logic f);
      write_reg(CSR_ORIGIN_X, ox);
      write_reg(CSR_ORIGIN_Y, oy);
      write_reg(CSR_INV_RADIUS_SQ, irsq);
      write_reg(CSR_CONE_HEIGHT, h);
      write_reg(CSR_INV_HEIGHT_SQ, ihsq);
      write_reg(CSR_GRAIN_ID, {16'b0, g});
      write_reg(CSR_FILL_SHELLS, {31'b0, f});
   endtask

   function automatic req_payload_type atom_item(input logic [31:0] x, input logic [31:0] y,
                                                 input logic [31:0] z, input logic [2:0] mat,
                                                 input logic [7:0] cat, input logic inc);
      req_payload_type p;
      p = '0;
      p.operation     = OP_CLASSIFY;
      p.pos_x         = x;
      p.pos_y         = y;
      p.pos_z         = z;
      p.atom_material = mat;
      p.atom_category = cat;
      p.include_in    = inc;
      return p;
   endfunction

   function automatic req_payload_type shell_item(input logic [2:0] idx, input logic [19:0] s,
                                                  input logic [31:0] zlo, input logic [31:0] zhi,
                                                  input logic [7:0] cat);
      req_payload_type p;
      p = '0;
      p.operation      = OP_LOAD;
      p.table_index    = idx;
      p.shell_radius   = s;
      p.shell_z_min    = zlo;
      p.shell_z_max    = zhi;
      p.shell_category = cat;
      return p;
   endfunction

   function automatic req_payload_type raw_item();
      req_payload_type p;
      p.operation      = 1'($urandom_range(0, 1));
      p.pos_x          = $urandom;
      p.pos_y          = $urandom;
      p.pos_z          = $urandom;
      p.atom_material  = 3'($urandom);
      p.atom_category  = 8'($urandom);
      p.include_in     = 1'($urandom);
      p.table_index    = 3'($urandom);
      p.shell_radius   = 20'($urandom);
      p.shell_z_min    = $urandom;
      p.shell_z_max    = $urandom;
      p.shell_category = 8'($urandom);
      return p;
   endfunction

   // coordinate in Q16.16 fixed point, about +-span units around the centre
   function automatic logic [31:0] near_coord(input logic [31:0] centre, input int span);
      int off;
      off = $urandom_range(0, 2 * span * 65536) - span * 65536;
      return centre + off;
   endfunction

   always @(negedge clock) begin
      if (pattern_age == 0) begin
         pattern_age   = $urandom_range(16, 96);
         ready_pattern = ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
      end
      pattern_age--;
      ready_pattern = {ready_pattern[6:0], ready_pattern[7]};
      rsp_if.ready <= ready_pattern[0];
   end

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_cls.size() == 0) begin
            report_mismatch("unexpected result beat", 1, 0);
         end else begin
            want = pending_cls.pop_front();
            if (rsp_if.data.include_out !== want.include_out)
               report_mismatch("include_out", rsp_if.data.include_out, want.include_out);
            if (rsp_if.data.material_out !== want.material_out)
               report_mismatch("material_out", rsp_if.data.material_out, want.material_out);
            if (rsp_if.data.grain_set !== want.grain_set)
               report_mismatch("grain_set", rsp_if.data.grain_set, want.grain_set);
         end
      end
   end

   task automatic test_reset_state();
      // zero registers: every atom sits on the cone, so all are included
      send_item(atom_item(32'h0, 32'h0, 32'h0, 3'd0, 8'd0, 1'b0));
      send_item(atom_item(32'h7FFFFFFF, 32'h80000000, 32'h12345678, 3'd7, 8'd255, 1'b1));
      drain_block();
   endtask

   task automatic test_extreme_fields();
      write_all_regs(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h80000000,
                     32'hFFFFFFFF, 16'hFFFF, 1'b1);
      send_item(atom_item(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 3'd7, 8'd255, 1'b0));
      send_item(atom_item(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 3'd0, 8'd0, 1'b1));
      send_item(atom_item(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 3'd3, 8'd1, 1'b0));
      drain_block();
      write_all_regs(32'h0, 32'h0, 32'h0, 32'h7FFFFFFF, 32'h0, 16'h0, 1'b0);
      send_item(atom_item(32'hFFFFFFFF, 32'h1, 32'h80000000, 3'd5, 8'd7, 1'b0));
      drain_block();
   endtask

   task automatic test_shell_walk();
      // base radius 8, height 16, apex at z = 16
      write_all_regs(32'h0, 32'h0, 32'h0400_0000, 32'h0010_0000, 32'h0100_0000, 16'd42, 1'b0);
      send_item(shell_item(3'd2, 20'h0C000, 32'hFFF0_0000, 32'h0010_0000, 8'd1));
      send_item(shell_item(3'd5, 20'h0C000, 32'h0, 32'h0008_0000, 8'd2));
      send_item(shell_item(3'd1, 20'h08000, 32'h8000_0000, 32'h7FFF_FFFF, 8'd1));
      send_item(shell_item(3'd7, 20'hFFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 8'd255));
      send_item(atom_item(32'h0001_0000, 32'h0, 32'h0, 3'd2, 8'd1, 1'b0));
      send_item(atom_item(32'h0, 32'h0, 32'h0004_0000, 3'd2, 8'd2, 1'b1));
      send_item(atom_item(32'h0006_0000, 32'h0, 32'h0, 3'd1, 8'd1, 1'b1));
      send_item(atom_item(32'h0, 32'h0, 32'h0, 3'd0, 8'd1, 1'b0));
      // no shell for the atom's own material: plain cone test
      send_item(atom_item(32'h0, 32'h0, 32'h0, 3'd4, 8'd0, 1'b0));
      drain_block();
      write_reg(CSR_FILL_SHELLS, 32'd1);
      send_item(atom_item(32'h0001_0000, 32'h0, 32'h0, 3'd5, 8'd9, 1'b1));
      send_item(atom_item(32'h0, 32'h0, 32'h0010_0000, 3'd7, 8'd2, 1'b0));
      drain_block();
   endtask

   task automatic test_random_phases();
      req_payload_type p;
      int unsigned     phase, n, sel, rad, hgt;
      for (phase = 0; phase < 8; phase++) begin
         if (phase == 7) begin
            write_all_regs(32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h7FFFFFFF,
                           32'h0, 16'h0, 1'b0);
         end else begin
            rad = $urandom_range(1, 64);
            hgt = $urandom_range(1, 64);
            write_all_regs($urandom_range(0, 1) ? 32'h0 : $urandom,
                           $urandom_range(0, 1) ? 32'h0 : $urandom,
                           32'hFFFF_FFFF / (rad * rad), hgt << 16,
                           32'hFFFF_FFFF / (hgt * hgt), 16'($urandom), phase[0]);
         end
         for (n = 0; n < 130; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 15) begin
               p = raw_item();
            end else if (sel < 35) begin
               p = shell_item(3'($urandom), ($urandom_range(0, 7) == 0) ? 20'h0
                              : 20'($urandom_range(13107, 78643)),
                              near_coord(32'h0, 40), near_coord(32'h0, 40),
                              8'($urandom_range(0, 3)));
            end else begin
               p = atom_item(near_coord(org_x, 2 * rad), near_coord(org_y, 2 * rad),
                             near_coord(32'h0, 2 * hgt), 3'($urandom),
                             8'($urandom_range(0, 3)), 1'($urandom));
            end
            send_item(p);
         end
         drain_block();
      end
   endtask

   initial begin
      reset        = 1'b1;
      csr_we       = 1'b0;
      csr_index    = CSR_ORIGIN_X;
      csr_wdata    = '0;
      req_if.valid = 1'b0;
      req_if.data  = '0;
      rsp_if.ready = 1'b0;
      pattern_age  = 0;
      burst_left   = 0;
      error_count  = 0;
      org_x = 0; org_y = 0; inv_rsq = 0; apex_z = 0; inv_hsq = 0;
      grain_num = 0; fill_on = 0;
      for (int i = 0; i < MATERIALS; i++) begin
         shell_size[i] = '0;
         shell_lo[i]   = '0;
         shell_hi[i]   = '0;
         shell_cat[i]  = '0;
      end
      repeat (10) @(negedge clock);
      reset = 1'b0;
      repeat (20) @(negedge clock);
      test_reset_state();
      test_extreme_fields();
      test_shell_walk();
      test_random_phases();
      drain_block();
      if (error_count == 0 && pending_cls.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
